// ===== rtl/upn_pkg.sv =====
package upn_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W   = 1;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_ALLOWED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWERCASE     = 1'd1;

    localparam logic [7:0] CH_PERCENT = 8'h25;

    typedef struct packed {
        logic [7:0] ch;
        logic       start_req;
        logic       at_end;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       stopped_on_char;
        logic       end_of_run;
    } result_t;

    typedef struct packed {
        logic [3:0] extra_allowed;
        logic       lowercase_mode;
    } cfg_t;

    // one queued command: a single result, or a re-encoded escape of three
    typedef struct packed {
        logic       triple;
        logic [7:0] byte_val;
        logic [1:0] kind;
        logic       stopped;
        logic [7:0] hex_hi;
        logic [7:0] hex_lo;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_req_t;

endpackage

// ===== rtl/upn_front.sv =====
module upn_front (
    input  logic             clk,
    input  logic             rst_n,
    input  upn_pkg::cfg_t    cfg,
    input  logic             item_valid,
    output logic             item_stall,
    input  upn_pkg::item_t   item,
    input  logic             queue_full,
    output upn_pkg::cmd_req_t push
);
    import upn_pkg::*;

    localparam logic [1:0] PH_PLAIN = 2'd0;
    localparam logic [1:0] PH_HEX1  = 2'd1;
    localparam logic [1:0] PH_HEX2  = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    function automatic logic is_allowed(input logic [7:0] c, input logic [3:0] extra);
        logic unres;
        logic sub;
        logic ext;
        unres = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
                (c >= 8'h30 && c <= 8'h39) || c == 8'h2d || c == 8'h2e ||
                c == 8'h5f || c == 8'h7e;
        // ! $ & ' ( ) * + , ; =
        sub = c == 8'h21 || c == 8'h24 || (c >= 8'h26 && c <= 8'h2c) ||
              c == 8'h3b || c == 8'h3d;
        ext = (c == 8'h40 && extra[0]) || (c == 8'h3a && extra[1]) ||
              (c == 8'h2f && extra[2]) || (c == 8'h3f && extra[3]);
        return unres || sub || c == CH_PERCENT || ext;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c[3:0];
        end
        else if (is_hex(c))
        begin
            v = c[3:0] + 4'd9;
        end
        else
        begin
            v = 4'd0;
        end
        return v;
    endfunction

    function automatic logic [7:0] hex_upper(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h66) ? (c - 8'h20) : c;
    endfunction

    logic [1:0] phase_reg, phase_next;
    logic [3:0] high_nibble_reg, high_nibble_next;
    logic [7:0] first_hex_reg, first_hex_next;

    logic       take;
    logic [1:0] phase_eff;
    logic [7:0] decoded;
    logic       bad_digit;

    assign item_stall = queue_full;
    assign take       = item_valid && !queue_full;
    assign phase_eff  = item.start_req ? PH_PLAIN : phase_reg;
    assign decoded    = {high_nibble_reg, hex_value(item.ch)};
    assign bad_digit  = item.at_end || !is_hex(item.ch);

    always_comb
    begin
        phase_next       = phase_reg;
        high_nibble_next = high_nibble_reg;
        first_hex_next   = first_hex_reg;
        push             = '0;
        if (take)
        begin
            phase_next = phase_eff;
            unique case (phase_eff)
                PH_PLAIN:
                begin
                    if (item.at_end)
                    begin
                        push.valid    = 1'b1;
                        push.cmd.kind = KIND_END;
                        phase_next    = PH_DONE;
                    end
                    else if (item.ch == CH_PERCENT)
                    begin
                        phase_next = PH_HEX1;
                    end
                    else if (is_allowed(item.ch, cfg.extra_allowed))
                    begin
                        push.valid        = 1'b1;
                        push.cmd.kind     = KIND_DATA;
                        push.cmd.byte_val = item.ch;
                        if (cfg.lowercase_mode && item.ch >= 8'h41 && item.ch <= 8'h5a)
                        begin
                            push.cmd.byte_val = item.ch + 8'h20;
                        end
                    end
                    else
                    begin
                        push.valid       = 1'b1;
                        push.cmd.kind    = KIND_END;
                        push.cmd.stopped = 1'b1;
                        phase_next       = PH_DONE;
                    end
                end
                PH_HEX1:
                begin
                    if (bad_digit)
                    begin
                        push.valid       = 1'b1;
                        push.cmd.kind    = KIND_BAD;
                        push.cmd.stopped = !item.at_end;
                        phase_next       = PH_DONE;
                    end
                    else
                    begin
                        high_nibble_next = hex_value(item.ch);
                        first_hex_next   = hex_upper(item.ch);
                        phase_next       = PH_HEX2;
                    end
                end
                PH_HEX2:
                begin
                    push.valid = 1'b1;
                    if (bad_digit)
                    begin
                        push.cmd.kind    = KIND_BAD;
                        push.cmd.stopped = !item.at_end;
                        phase_next       = PH_DONE;
                    end
                    else
                    begin
                        push.cmd.kind = KIND_DATA;
                        phase_next    = PH_PLAIN;
                        if (decoded != CH_PERCENT && is_allowed(decoded, cfg.extra_allowed))
                        begin
                            push.cmd.byte_val = decoded;
                        end
                        else
                        begin
                            // keep the escape, hex digits forced to upper case
                            push.cmd.triple = 1'b1;
                            push.cmd.hex_hi = first_hex_reg;
                            push.cmd.hex_lo = hex_upper(item.ch);
                        end
                    end
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_PLAIN;
            high_nibble_reg <= 4'd0;
            first_hex_reg   <= 8'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            high_nibble_reg <= high_nibble_next;
            first_hex_reg   <= first_hex_next;
        end
    end

endmodule

// ===== rtl/upn_queue.sv =====
module upn_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  upn_pkg::cmd_req_t push,
    output logic              full,
    input  logic              pop,
    output upn_pkg::cmd_req_t head
);
    import upn_pkg::*;

    cmd_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full       = count_reg == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.cmd   = mem[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/upn_back.sv =====
module upn_back (
    input  logic              clk,
    input  logic              rst_n,
    input  upn_pkg::cmd_req_t head,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_stall,
    output upn_pkg::result_t  result
);
    import upn_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    result_t    result_reg, result_next;
    logic       load;
    logic       take;
    logic       last;

    assign load = !valid_reg || !result_stall;
    assign take = load && head.valid;
    assign last = !head.cmd.triple || idx_reg == 2'd2;
    assign pop  = take && last;

    always_comb
    begin
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        result_next = result_reg;
        if (load)
        begin
            valid_next = head.valid;
        end
        if (take)
        begin
            idx_next                = last ? 2'd0 : idx_reg + 2'd1;
            result_next.kind        = head.cmd.kind;
            result_next.stopped_on_char = head.cmd.stopped;
            result_next.end_of_run  = last;
            if (head.cmd.triple)
            begin
                case (idx_reg)
                    2'd0:    result_next.out_byte = CH_PERCENT;
                    2'd1:    result_next.out_byte = head.cmd.hex_hi;
                    default: result_next.out_byte = head.cmd.hex_lo;
                endcase
            end
            else
            begin
                result_next.out_byte = head.cmd.byte_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/uri_pchar_percent_normalizer.sv =====
// Normalises a run of URI pchar characters, one character per request.
// Item channel: item_valid / item_stall / item {ch, start_req, at_end}.
// Result channel: result_valid / result_stall / result
//   {out_byte, kind, stopped_on_char, end_of_run}; each item gives 0 to 3
//   results, end_of_run marking the last one of that item.
// Config channel: cfg_valid / cfg_ready / cfg_index / cfg_data; index 0 is the
//   extra-allowed mask, index 1 lowercase mode. cfg_ready is always high.
// Throughput: one item per cycle while the queue is not full. The front end
//   classifies an item in the cycle it is taken; a 4-entry command queue feeds
//   the back end, which sends one result per cycle while result_stall is low.
//   A re-encoded escape holds it for its three results. An accepted item's
//   command is queued first, then its results pass the output register.
// item_stall rises only while the queue is full; a stalled result holds in
//   the output register while the front end keeps taking items.
// Reset: empty queue, no valid result, collecting phase, mask 3, no lowercase.
module uri_pchar_percent_normalizer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  upn_pkg::item_t                    item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output upn_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [upn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [3:0]                        cfg_data
);
    import upn_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    cmd_req_t push;
    cmd_req_t head;
    logic     queue_full;
    logic     pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_EXTRA_ALLOWED: cfg_next.extra_allowed  = cfg_data;
                CFG_LOWERCASE:     cfg_next.lowercase_mode = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.extra_allowed  <= 4'd3;
            cfg_reg.lowercase_mode <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    upn_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .queue_full (queue_full),
        .push       (push)
    );

    upn_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .pop   (pop),
        .head  (head)
    );

    upn_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // an end or error result always closes its request
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind != KIND_DATA |-> result.end_of_run)
        else $error("end/error result without end_of_run");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind != KIND_DATA |-> result.out_byte == 8'd0)
        else $error("non-data result carries a byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_DATA |-> !result.stopped_on_char)
        else $error("data result flagged as stopped");

    // a taken result that does not end its escape is followed by a further valid result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result.end_of_run |=> result_valid)
        else $error("escape sequence broken off");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import upn_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES   = 4;

    localparam logic [3:0] PHASE_MASK  [4] = '{4'd0, 4'd15, 4'd5, 4'd10};
    localparam logic [3:0] PHASE_LOWER [4] = '{4'd0, 4'd1, 4'd1, 4'd0};
    localparam int         PHASE_IDLE  [4] = '{0, 49, 0, 26};
    localparam int         PHASE_STALL [4] = '{0, 0, 49, 26};

    typedef enum logic [1:0] {COLLECT, HEX_FIRST, HEX_SECOND, RUN_DONE} run_phase_t;

    // one stimulus row: either checked by the predictor or with a typed-in result
    typedef struct packed {
        item_t   it;
        logic    typed;
        logic    has_res;
        result_t res;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    item_t                item;
    logic                 result_valid;
    logic                 result_stall;
    result_t              result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [3:0]           cfg_data;

    // predictor state
    cfg_t       norm_cfg;
    run_phase_t run_phase;
    logic [3:0] hi_nibble;
    logic [7:0] hi_char;

    result_t normalized_q[$];
    int      mismatches = 0;
    int      items_taken = 0;
    int      quiet_cycles = 0;
    int      send_idle_pct = 0;
    int      stall_pct = 0;
    logic    hold_off_req = 1'b0;
    string   plain_pool = "AQZazm09-._~!$&'()*+,;=@:/?";

    uri_pchar_percent_normalizer dut (
        .clk,
        .rst_n,
        .item_valid,
        .item_stall,
        .item,
        .result_valid,
        .result_stall,
        .result,
        .cfg_valid,
        .cfg_ready,
        .cfg_index,
        .cfg_data
    );

    always #5 clk = ~clk;

    function automatic logic char_allowed(input logic [7:0] c);
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9"))
            return 1'b1;
        if (c inside {"-", ".", "_", "~", "!", "$", "&", "'", "(", ")", "*", "+", ",", ";",
                      "=", CH_PERCENT})
            return 1'b1;
        return (c == "@" && norm_cfg.extra_allowed[0]) || (c == ":" && norm_cfg.extra_allowed[1])
            || (c == "/" && norm_cfg.extra_allowed[2]) || (c == "?" && norm_cfg.extra_allowed[3]);
    endfunction

    function automatic logic is_hex_digit(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        if (c >= "a" && c <= "f")
            v = c - "a" + 8'd10;
        else if (c >= "A" && c <= "F")
            v = c - "A" + 8'd10;
        else
            v = c - "0";
        return v[3:0];
    endfunction

    function automatic logic [7:0] hex_upper(input logic [7:0] c);
        if (c >= "a" && c <= "f")
            return c - 8'h20;
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic up);
        if (v < 4'd10)
            return "0" + 8'(v);
        return (up ? "A" : "a") + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] pick_plain();
        return plain_pool[$urandom_range(plain_pool.len() - 1)];
    endfunction

    function automatic dir_row_t row_pred(input logic [7:0] c, input logic s, input logic e);
        return {c, s, e, 1'b0, 1'b0, 12'h000};
    endfunction

    function automatic dir_row_t row_exp(input logic [7:0] c, input logic s, input logic e,
                                         input logic has, input logic [7:0] b,
                                         input logic [1:0] k, input logic st);
        return {c, s, e, 1'b1, has, b, k, st, 1'b1};
    endfunction

    // advances the predictor by one request and returns the number of results
    function automatic int normalize_item(input item_t it, output result_t outs[3]);
        int         n;
        logic [7:0] c;
        logic [7:0] dec;
        n = 0;
        foreach (outs[i])
            outs[i] = '0;
        if (it.start_req)
            run_phase = COLLECT;
        case (run_phase)
            COLLECT:
            begin
                if (it.at_end)
                begin
                    outs[n] = {8'h00, KIND_END, 1'b0, 1'b0};
                    n++;
                    run_phase = RUN_DONE;
                end
                else if (it.ch == CH_PERCENT)
                    run_phase = HEX_FIRST;
                else if (char_allowed(it.ch))
                begin
                    c = it.ch;
                    if (norm_cfg.lowercase_mode && c >= "A" && c <= "Z")
                        c = c + 8'h20;
                    outs[n] = {c, KIND_DATA, 1'b0, 1'b0};
                    n++;
                end
                else
                begin
                    outs[n] = {8'h00, KIND_END, 1'b1, 1'b0};
                    n++;
                    run_phase = RUN_DONE;
                end
            end
            HEX_FIRST, HEX_SECOND:
            begin
                if (it.at_end || !is_hex_digit(it.ch))
                begin
                    outs[n] = {8'h00, KIND_BAD, !it.at_end, 1'b0};
                    n++;
                    run_phase = RUN_DONE;
                end
                else if (run_phase == HEX_FIRST)
                begin
                    hi_nibble = hex_nibble(it.ch);
                    hi_char   = hex_upper(it.ch);
                    run_phase = HEX_SECOND;
                end
                else
                begin
                    dec = {hi_nibble, hex_nibble(it.ch)};
                    if (dec != CH_PERCENT && char_allowed(dec))
                    begin
                        outs[n] = {dec, KIND_DATA, 1'b0, 1'b0};
                        n++;
                    end
                    else
                    begin
                        // re-encode with both digits in upper case
                        outs[0] = {CH_PERCENT, KIND_DATA, 1'b0, 1'b0};
                        outs[1] = {hi_char, KIND_DATA, 1'b0, 1'b0};
                        outs[2] = {hex_upper(it.ch), KIND_DATA, 1'b0, 1'b0};
                        n = 3;
                    end
                    run_phase = COLLECT;
                end
            end
            default:
            begin
            end
        endcase
        if (n > 0)
            outs[n - 1].end_of_run = 1'b1;
        return n;
    endfunction

    task automatic send_row(input dir_row_t r);
        result_t outs[3];
        int      n;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= r.it;
        // hold the request until the block takes it
        do
            @(posedge clk);
        while (item_stall);
        if (!(run_phase == RUN_DONE && !r.it.start_req))
            items_taken++;
        n = normalize_item(r.it, outs);
        if (r.typed)
        begin
            if (r.has_res)
                normalized_q.push_back(r.res);
        end
        else
        begin
            for (int i = 0; i < n; i++)
                normalized_q.push_back(outs[i]);
        end
        @(negedge clk);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        do
            @(negedge clk);
        while (normalized_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] data);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_EXTRA_ALLOWED)
            norm_cfg.extra_allowed = data;
        else
            norm_cfg.lowercase_mode = data[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed runs with random content, plus broken escapes and noise
    task automatic drive_random(input int n_items);
        int         target;
        int         sel;
        logic       s;
        logic [7:0] c;
        logic [7:0] v;
        target = items_taken + n_items;
        while (items_taken < target)
        begin
            s = (run_phase == RUN_DONE) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0);
            sel = $urandom_range(99);
            if (sel < 45)
                send_row(row_pred(pick_plain(), s, 1'b0));
            else if (sel < 70)
            begin
                v = 8'($urandom_range(255));
                send_row(row_pred(CH_PERCENT, s, 1'b0));
                send_row(row_pred(hex_char(v[7:4], 1'($urandom_range(1))), 1'b0, 1'b0));
                send_row(row_pred(hex_char(v[3:0], 1'($urandom_range(1))), 1'b0, 1'b0));
            end
            else if (sel < 78)
            begin
                send_row(row_pred(CH_PERCENT, s, 1'b0));
                if ($urandom_range(1) == 1)
                    send_row(row_pred(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))),
                                      1'b0, 1'b0));
                if ($urandom_range(1) == 1)
                    send_row(row_pred(8'($urandom_range(255)), 1'b0, 1'b1));
                else
                begin
                    do
                        c = 8'($urandom_range(255));
                    while (is_hex_digit(c));
                    send_row(row_pred(c, 1'b0, 1'b0));
                end
            end
            else if (sel < 90)
                send_row(row_pred(8'($urandom_range(255)), s, $urandom_range(3) == 0));
            else
                send_row(row_pred(8'($urandom_range(255)), 1'($urandom_range(1)),
                                  1'($urandom_range(1))));
            if ($urandom_range(49) == 0)
                wait_drained();
        end
    endtask

    task automatic check_field(input string fname, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (normalized_q.size() == 0)
            begin
                $error("result with nothing pending: out_byte %0h kind %0d",
                       result.out_byte, result.kind);
                mismatches++;
            end
            else
            begin
                want = normalized_q.pop_front();
                check_field("out_byte", want.out_byte, result.out_byte);
                check_field("kind", 8'(want.kind), 8'(result.kind));
                check_field("stopped_on_char", 8'(want.stopped_on_char),
                            8'(result.stopped_on_char));
                check_field("end_of_run", 8'(want.end_of_run), 8'(result.end_of_run));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // receiver side: random stalls, or one long hold-off on request
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        dir_row_t dir_rows[$];
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        norm_cfg   = '{extra_allowed: 4'd3, lowercase_mode: 1'b0};
        run_phase  = COLLECT;
        hi_nibble  = '0;
        hi_char    = '0;

        // reset settings: '@' and ':' extra, no lowercasing
        dir_rows = '{
            row_exp("a", 1, 0, 1, "a", KIND_DATA, 0),
            row_exp("Z", 0, 0, 1, "Z", KIND_DATA, 0),
            row_exp(CH_PERCENT, 0, 0, 0, 8'h00, KIND_DATA, 0),
            row_exp("4", 0, 0, 0, 8'h00, KIND_DATA, 0),
            row_pred("1", 0, 0),
            row_pred(CH_PERCENT, 0, 0),
            row_pred("2", 0, 0),
            row_pred("5", 0, 0),
            row_pred(CH_PERCENT, 0, 0),
            row_pred("2", 0, 0),
            row_pred("f", 0, 0),
            row_exp("@", 0, 0, 1, "@", KIND_DATA, 0),
            row_exp(":", 0, 0, 1, ":", KIND_DATA, 0),
            row_exp(8'hFF, 0, 0, 1, 8'h00, KIND_END, 1),
            row_exp("a", 0, 0, 0, 8'h00, KIND_DATA, 0),
            row_exp(8'h00, 1, 1, 1, 8'h00, KIND_END, 0),
            row_pred(CH_PERCENT, 1, 0),
            row_exp("g", 0, 0, 1, 8'h00, KIND_BAD, 1),
            row_pred(CH_PERCENT, 1, 0),
            row_exp(8'hFF, 0, 1, 1, 8'h00, KIND_BAD, 0),
            row_pred(CH_PERCENT, 1, 0),
            row_pred("a", 0, 0),
            row_exp("z", 0, 0, 1, 8'h00, KIND_BAD, 1),
            row_pred(CH_PERCENT, 1, 0),
            row_exp("b", 1, 0, 1, "b", KIND_DATA, 0)
        };

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_row(dir_rows[i]);

        for (int p = 0; p < 4; p++)
        begin
            write_reg(CFG_EXTRA_ALLOWED, PHASE_MASK[p]);
            write_reg(CFG_LOWERCASE, PHASE_LOWER[p]);
            send_idle_pct = PHASE_IDLE[p];
            stall_pct     = PHASE_STALL[p];
            drive_random(50);
        end

        // long receiver hold-off with a steady stream of plain characters
        write_reg(CFG_EXTRA_ALLOWED, 4'hF);
        write_reg(CFG_LOWERCASE, 4'h1);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_off_req  = 1'b1;
        for (int i = 0; i < 30; i++)
            send_row(row_pred(pick_plain(), i == 0, 1'b0));

        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatches == 0 && normalized_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
